// File: rtl/core/safs_pkg.sv
// Shared constants, configuration and control types for the sprite animation frame stepper.
package safs_pkg;

    // Fixed field widths
    localparam int unsigned FC_W       = 9;
    localparam int unsigned DUR_W      = 20;
    localparam int unsigned FDIM_W     = 10;
    localparam int unsigned SPEED_W    = 12;
    localparam int unsigned STEP_W     = 16;
    localparam int unsigned ELAPSED_W  = 26;
    localparam int unsigned RECT_W     = 18;
    localparam int unsigned ALPHA_W    = 8;

    // Timing and frame limits
    localparam int unsigned TIME_FRAC_BITS = 10;
    localparam int unsigned SPEED_FRAC     = 8;
    localparam int unsigned MAX_FRAMES     = 256;
    localparam int unsigned COLS_MAX       = 16;
    localparam int unsigned COLS_W         = 5;

    // Shared divider: quotient bits per run, numerator width
    localparam int unsigned QUOT_W = 8;
    localparam int unsigned NUM_W  = DUR_W + QUOT_W;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_FRAME_COUNT   = 3'd0;
    localparam logic [2:0] REG_DURATION      = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_LAYOUT_MODE   = 3'd4;
    localparam logic [2:0] REG_FLIP_FLAGS    = 3'd5;
    localparam logic [2:0] REG_SPEED_FACTOR  = 3'd6;
    localparam logic [2:0] REG_PLAY_REVERSED = 3'd7;

    typedef struct packed {
        logic [FC_W-1:0]    frame_count;
        logic [DUR_W-1:0]   duration;
        logic [FDIM_W-1:0]  frame_width;
        logic [FDIM_W-1:0]  frame_height;
        logic               layout_mode;
        logic [1:0]         flip_flags;
        logic [SPEED_W-1:0] speed_factor;
        logic               play_reversed;
    } cfg_t;

    typedef enum logic [1:0] {
        DIV_SEL_ALPHA = 2'd0,
        DIV_SEL_INDEX = 2'd1,
        DIV_SEL_GRID  = 2'd2
    } div_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     take_in;
        logic     elapsed_upd;
        logic     div_start;
        div_sel_t div_sel;
        logic     alpha_take;
        logic     idx_check;
        logic     k_take;
        logic     rect_upd;
        logic     out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
        logic done;
        logic grid;
    } sts_t;

endpackage

// File: rtl/core/sprite_animation_frame_stepper.sv
// A finished step takes only the alpha division, row layout adds the index division,
// grid layout also the grid division; the shared divider runs once per division.
// Only one word is in flight at a time; a result waiting in the output register
// does not hold off the next input word.
// Reset: synchronous active-low aresetn loads register defaults and clears elapsed time.
module sprite_animation_frame_stepper import safs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] time_step
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [17:0] rect_left, [35:18] rect_top, [43:36] fade_alpha
    output logic [0:0]  m_tuser    // [0] finished
);

    cfg_t          cfg_reg, cfg_next;
    logic          wr_en;
    logic [2:0]    reg_idx;
    logic          acc_load;
    cmd_t          cmd;
    sts_t          sts;
    logic          out_finished;
    logic [RECT_W-1:0]  out_left, out_top;
    logic [ALPHA_W-1:0] out_alpha;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        acc_load = 1'b0;
        if (wr_en) begin
            case (reg_idx)
                REG_FRAME_COUNT:   cfg_next.frame_count   = pwdata[FC_W-1:0];
                REG_DURATION:      cfg_next.duration      = pwdata[DUR_W-1:0];
                REG_FRAME_WIDTH:   cfg_next.frame_width   = pwdata[FDIM_W-1:0];
                REG_FRAME_HEIGHT:  cfg_next.frame_height  = pwdata[FDIM_W-1:0];
                REG_LAYOUT_MODE:   cfg_next.layout_mode   = pwdata[0];
                REG_FLIP_FLAGS:    cfg_next.flip_flags    = pwdata[1:0];
                REG_SPEED_FACTOR:  cfg_next.speed_factor  = pwdata[SPEED_W-1:0];
                REG_PLAY_REVERSED: begin
                    cfg_next.play_reversed = pwdata[0];
                    acc_load               = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_count   <= FC_W'(1);
            cfg_reg.duration      <= DUR_W'(1 << TIME_FRAC_BITS);
            cfg_reg.frame_width   <= FDIM_W'(16);
            cfg_reg.frame_height  <= FDIM_W'(16);
            cfg_reg.layout_mode   <= 1'b0;
            cfg_reg.flip_flags    <= 2'b00;
            cfg_reg.speed_factor  <= SPEED_W'(1 << SPEED_FRAC);
            cfg_reg.play_reversed <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            REG_FRAME_COUNT:   prdata = 32'(cfg_reg.frame_count);
            REG_DURATION:      prdata = 32'(cfg_reg.duration);
            REG_FRAME_WIDTH:   prdata = 32'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:  prdata = 32'(cfg_reg.frame_height);
            REG_LAYOUT_MODE:   prdata = 32'(cfg_reg.layout_mode);
            REG_FLIP_FLAGS:    prdata = 32'(cfg_reg.flip_flags);
            REG_SPEED_FACTOR:  prdata = 32'(cfg_reg.speed_factor);
            REG_PLAY_REVERSED: prdata = 32'(cfg_reg.play_reversed);
            default:           prdata = '0;
        endcase
    end

    safs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    safs_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .acc_load     (acc_load),
        .acc_rev      (pwdata[0]),
        .s_step       (s_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .out_finished (out_finished),
        .out_left     (out_left),
        .out_top      (out_top),
        .out_alpha    (out_alpha)
    );

    assign m_tdata = {4'b0, out_alpha, out_top, out_left};
    assign m_tuser = out_finished;

endmodule

// File: rtl/core/safs_div.sv
// Shared restoring divider: one quotient bit per cycle, QUOT_W quotient bits per run.
module safs_div import safs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DUR_W-1:0]  den,
    output logic              last,
    output logic [QUOT_W-1:0] quot,
    output logic [DUR_W-1:0]  rem
);

    localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] nq_reg, nq_next;
    logic [DUR_W-1:0]  den_reg, den_next;
    logic [DUR_W:0]    trial;
    logic              qbit;

    // One trial subtraction per cycle; numerator low bits shift out as quotient shifts in
    always_comb begin
        trial    = {rem_reg, nq_reg[QUOT_W-1]};
        qbit     = trial >= {1'b0, den_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        nq_next  = nq_reg;
        den_next = den_reg;
        if (start) begin
            cnt_next = CNT_W'(QUOT_W);
            rem_next = num[NUM_W-1:QUOT_W];
            nq_next  = num[QUOT_W-1:0];
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - CNT_W'(1);
            rem_next = qbit ? DUR_W'(trial - {1'b0, den_reg}) : trial[DUR_W-1:0];
            nq_next  = {nq_reg[QUOT_W-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_next;
    end

    assign last = (cnt_reg == CNT_W'(1));
    assign quot = nq_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/core/safs_dp.sv
// Datapath: elapsed-time accumulator, alpha and frame index, rectangle origin, output word.
module safs_dp import safs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              acc_load,
    input  logic              acc_rev,
    input  logic [STEP_W-1:0] s_step,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              out_finished,
    output logic [RECT_W-1:0] out_left,
    output logic [RECT_W-1:0] out_top,
    output logic [ALPHA_W-1:0] out_alpha
);

    localparam int unsigned PROD_W  = ELAPSED_W + FC_W;
    localparam int unsigned SPROD_W = STEP_W + SPEED_W;
    localparam int unsigned DELTA_W = SPROD_W - SPEED_FRAC;
    localparam int unsigned K_W     = $clog2(MAX_FRAMES);

    // Floor square root over the frame count range
    function automatic logic [COLS_W-1:0] isqrt_cols(input logic [FC_W-1:0] v);
        logic [COLS_W-1:0] cnt;
        cnt = '0;
        for (int r = 1; r <= COLS_MAX; r++) begin
            if (r * r <= int'(v))
                cnt = cnt + COLS_W'(1);
        end
        return cnt;
    endfunction

    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [DELTA_W-1:0]   delta_reg;
    logic [ELAPSED_W:0]   diff_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [COLS_W-1:0]    cols_reg;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic                 done_reg;
    logic [K_W-1:0]       k_reg;
    logic [RECT_W-1:0]    last_left_reg, last_top_reg;
    logic                 fin_out_reg;
    logic [RECT_W-1:0]    left_out_reg, top_out_reg;
    logic [ALPHA_W-1:0]   alpha_out_reg;

    logic [FC_W-1:0]      fc;
    logic [SPROD_W-1:0]   step_prod;
    logic [ELAPSED_W:0]   acc_sum;
    logic [ELAPSED_W-1:0] acc_sat;
    logic [ELAPSED_W-1:0] mag;
    logic                 dur_zero;
    logic                 done_now;
    logic                 diff_le0, diff_ge_dur;
    logic [NUM_W-1:0]     alpha_num;
    logic [NUM_W-1:0]     div_num;
    logic [DUR_W-1:0]     div_den;
    logic                 div_start;
    logic                 div_last;
    logic [QUOT_W-1:0]    div_quot;
    logic [DUR_W-1:0]     div_rem;
    logic [K_W-1:0]       mul_k;
    logic [RECT_W-1:0]    left_next, top_next;

    // Clamped frame count and scaled step
    assign fc        = (cfg.frame_count > FC_W'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES)
                                                              : cfg.frame_count;
    assign step_prod = SPROD_W'(s_step) * SPROD_W'(cfg.speed_factor);
    assign dur_zero  = (cfg.duration == '0);

    // Accumulator advance with saturation at the signed limits
    always_comb begin
        if (cfg.play_reversed)
            acc_sum = {elapsed_reg[ELAPSED_W-1], elapsed_reg} - (ELAPSED_W+1)'(delta_reg);
        else
            acc_sum = {elapsed_reg[ELAPSED_W-1], elapsed_reg} + (ELAPSED_W+1)'(delta_reg);
        if (acc_sum[ELAPSED_W] != acc_sum[ELAPSED_W-1])
            acc_sat = acc_sum[ELAPSED_W] ? {1'b1, {(ELAPSED_W-1){1'b0}}}
                                         : {1'b0, {(ELAPSED_W-1){1'b1}}};
        else
            acc_sat = acc_sum[ELAPSED_W-1:0];
    end

    always_comb begin
        elapsed_next = elapsed_reg;
        if (acc_load)
            elapsed_next = acc_rev ? ELAPSED_W'(cfg.duration) : '0;
        else if (cmd.elapsed_upd)
            elapsed_next = acc_sat;
    end

    // Magnitude of elapsed time for the index product
    assign mag = elapsed_reg[ELAPSED_W-1] ? (~elapsed_reg + ELAPSED_W'(1)) : elapsed_reg;

    // Index range check: negative times are in range only while |e|*fc < duration
    assign done_now = dur_zero || (fc == '0)
                   || (!elapsed_reg[ELAPSED_W-1] && (elapsed_reg >= ELAPSED_W'(cfg.duration)))
                   || (elapsed_reg[ELAPSED_W-1] && (prod_reg >= PROD_W'(cfg.duration)));

    // Alpha cases from remaining time before the step
    assign diff_le0    = diff_reg[ELAPSED_W] || (diff_reg == '0);
    assign diff_ge_dur = !diff_reg[ELAPSED_W]
                      && (diff_reg[ELAPSED_W-1:0] >= ELAPSED_W'(cfg.duration));
    assign alpha_num   = {diff_reg[DUR_W-1:0], {QUOT_W{1'b0}}}
                       - NUM_W'(diff_reg[DUR_W-1:0]);

    // Divider operand selection
    always_comb begin
        case (cmd.div_sel)
            DIV_SEL_ALPHA: begin
                div_num = alpha_num;
                div_den = cfg.duration;
            end
            DIV_SEL_INDEX: begin
                div_num = prod_reg[NUM_W-1:0];
                div_den = cfg.duration;
            end
            DIV_SEL_GRID: begin
                div_num = NUM_W'(div_quot);
                div_den = DUR_W'(cols_reg);
            end
            default: begin
                div_num = alpha_num;
                div_den = cfg.duration;
            end
        endcase
    end

    assign div_start = cmd.div_start;

    safs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .last    (div_last),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // Rectangle origin: row layout uses k, grid uses remainder and quotient
    assign mul_k     = cfg.layout_mode ? K_W'(div_rem[COLS_W-2:0]) : k_reg;
    assign left_next = RECT_W'((cfg.flip_flags[0] ? RECT_W'(cfg.frame_width) : '0)
                     + RECT_W'(cfg.frame_width) * RECT_W'(mul_k));
    assign top_next  = RECT_W'((cfg.flip_flags[1] ? RECT_W'(cfg.frame_height) : '0)
                     + (cfg.layout_mode ? RECT_W'(cfg.frame_height) * RECT_W'(div_quot)
                                        : '0));

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg   <= '0;
            last_left_reg <= '0;
            last_top_reg  <= '0;
        end else begin
            elapsed_reg <= elapsed_next;
            if (cmd.rect_upd) begin
                last_left_reg <= left_next;
                last_top_reg  <= top_next;
            end
        end
    end

    // Working and output word registers
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mag) * PROD_W'(fc);
        cols_reg <= isqrt_cols(fc);
        if (cmd.take_in) begin
            delta_reg <= step_prod[SPROD_W-1:SPEED_FRAC];
            diff_reg  <= (ELAPSED_W+1)'(cfg.duration)
                       - {elapsed_reg[ELAPSED_W-1], elapsed_reg};
        end
        if (cmd.alpha_take) begin
            if (dur_zero || diff_le0)
                alpha_reg <= '0;
            else if (diff_ge_dur)
                alpha_reg <= '1;
            else
                alpha_reg <= div_quot;
        end
        if (cmd.idx_check)
            done_reg <= done_now;
        if (cmd.k_take)
            k_reg <= div_quot;
        if (cmd.out_load) begin
            fin_out_reg   <= done_reg;
            left_out_reg  <= last_left_reg;
            top_out_reg   <= last_top_reg;
            alpha_out_reg <= alpha_reg;
        end
    end

    assign sts.div_last = div_last;
    assign sts.done     = done_now;
    assign sts.grid     = cfg.layout_mode;

    assign out_finished = fin_out_reg;
    assign out_left     = left_out_reg;
    assign out_top      = top_out_reg;
    assign out_alpha    = alpha_out_reg;

endmodule

// File: rtl/core/safs_ctrl.sv
// Controller: takes one tick through alpha, and index and grid as needed; hands off the word.
module safs_ctrl import safs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_ALPHA  = 9'b000000010,
        ST_ADIV   = 9'b000000100,
        ST_INDEX  = 9'b000001000,
        ST_IDIV   = 9'b000010000,
        ST_GSTART = 9'b000100000,
        ST_GDIV   = 9'b001000000,
        ST_RECT   = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_SEL_ALPHA;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_ALPHA;
                end
            end
            ST_ALPHA: begin
                cmd.elapsed_upd = 1'b1;
                cmd.div_start   = 1'b1;
                cmd.div_sel     = DIV_SEL_ALPHA;
                state_next      = ST_ADIV;
            end
            ST_ADIV: begin
                if (sts.div_last)
                    state_next = ST_INDEX;
            end
            ST_INDEX: begin
                cmd.alpha_take = 1'b1;
                cmd.idx_check  = 1'b1;
                if (sts.done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_INDEX;
                    state_next    = ST_IDIV;
                end
            end
            ST_IDIV: begin
                if (sts.div_last)
                    state_next = ST_GSTART;
            end
            ST_GSTART: begin
                cmd.k_take = 1'b1;
                if (sts.grid) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_GRID;
                    state_next    = ST_GDIV;
                end else begin
                    state_next = ST_RECT;
                end
            end
            ST_GDIV: begin
                if (sts.div_last)
                    state_next = ST_RECT;
            end
            ST_RECT: begin
                cmd.rect_upd = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb begin
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule
